### hdl/mkpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpc_pkg
// Shared widths, register indexes, reset values and the config bundle for
// the multi-key press classifier.
// ----------------------------------------------------------------------------
package mkpc_pkg;

  localparam int TICK_W         = 16;
  localparam int CNT_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int KEY_IDX_W      = 4;
  localparam int KIND_W         = 3;
  localparam int DEF_KEY_COUNT  = 16;
  localparam int DEF_FIFO_DEPTH = 4;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_DB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd5;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_PRESS_DB = 16'd2;
  localparam logic [CNT_W-1:0] RST_REL_DB   = 16'd2;
  localparam logic [CNT_W-1:0] RST_LONG1    = 16'd100;
  localparam logic [CNT_W-1:0] RST_LONG2    = 16'd200;
  localparam logic [CNT_W-1:0] RST_LONG3    = 16'd300;
  localparam logic [CNT_W-1:0] RST_GAP      = 16'd30;

  typedef struct packed {
    logic [CNT_W-1:0] press_db;
    logic [CNT_W-1:0] rel_db;
    logic [CNT_W-1:0] long1;
    logic [CNT_W-1:0] long2;
    logic [CNT_W-1:0] long3;
    logic [CNT_W-1:0] gap;
  } cfg_t;

endpackage

### hdl/mkpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpc_front
// Per-key state machines. All keys step in parallel on an accepted tick and
// the tick's event mask, kinds and held flags are queued if any key fires.
// ----------------------------------------------------------------------------
module mkpc_front #(
  parameter int KEY_COUNT = mkpc_pkg::DEF_KEY_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mkpc_pkg::cfg_t                cfg,
  input  logic                          accept,
  input  logic [mkpc_pkg::TICK_W-1:0]   raw_pressed,
  output logic                          push,
  output logic [KEY_COUNT*5-1:0]        push_data
);
  import mkpc_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PRE   = 3'd1;
  localparam logic [2:0] PH_HELD  = 3'd2;
  localparam logic [2:0] PH_LONG1 = 3'd3;
  localparam logic [2:0] PH_LONG2 = 3'd4;
  localparam logic [2:0] PH_LONG3 = 3'd5;
  localparam logic [2:0] PH_REL   = 3'd6;
  localparam logic [2:0] PH_WAIT  = 3'd7;

  localparam logic [KIND_W-1:0] EV_SHORT  = 3'd0;
  localparam logic [KIND_W-1:0] EV_LONG1  = 3'd1;
  localparam logic [KIND_W-1:0] EV_LONG2  = 3'd2;
  localparam logic [KIND_W-1:0] EV_LONG3  = 3'd3;
  localparam logic [KIND_W-1:0] EV_DOUBLE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [KEY_COUNT-1:0]             ev_mask;
  logic [KEY_COUNT-1:0][KIND_W-1:0] ev_kind;
  logic [KEY_COUNT-1:0]             ev_held;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    logic [2:0]        phase, phase_next;
    logic [2:0]        prev_phase, prev_phase_next;
    logic [CNT_W-1:0]  gap_cnt, gap_cnt_next;
    logic [CNT_W-1:0]  held_cnt, held_cnt_next;
    logic [1:0]        tally, tally_next;
    logic [CNT_W-1:0]  gap_inc, held_inc;
    logic              down;
    logic              ev_fire;
    logic [KIND_W-1:0] ev_code;
    logic              ev_still;

    assign down     = raw_pressed[k];
    assign gap_inc  = (gap_cnt == CNT_MAX) ? gap_cnt : gap_cnt + 16'd1;
    assign held_inc = (held_cnt == CNT_MAX) ? held_cnt : held_cnt + 16'd1;

    assign ev_mask[k] = ev_fire;
    assign ev_kind[k] = ev_code;
    assign ev_held[k] = ev_still;

    always_comb begin
      phase_next      = phase;
      prev_phase_next = prev_phase;
      gap_cnt_next    = gap_cnt;
      held_cnt_next   = held_cnt;
      tally_next      = tally;
      ev_fire         = 1'b0;
      ev_code         = EV_SHORT;
      ev_still        = 1'b1;
      case (phase)
        PH_IDLE: begin
          if (down) begin
            prev_phase_next = phase;
            phase_next      = PH_PRE;
            gap_cnt_next    = '0;
          end
        end
        PH_PRE: begin
          if (down) begin
            if (gap_inc >= cfg.press_db) begin
              gap_cnt_next    = '0;
              held_cnt_next   = '0;
              tally_next      = (tally == 2'd3) ? tally : tally + 2'd1;
              prev_phase_next = phase;
              phase_next      = PH_HELD;
              ev_fire         = 1'b1;
              ev_code         = EV_SHORT;
            end else begin
              gap_cnt_next = gap_inc;
            end
          end else begin
            // bounce: back to where we came from, gap count kept
            phase_next = prev_phase;
          end
        end
        PH_HELD, PH_LONG1, PH_LONG2: begin
          if (down) begin
            held_cnt_next = held_inc;
            if (phase == PH_HELD && tally == 2'd1 && held_inc == cfg.long1) begin
              prev_phase_next = phase;
              phase_next      = PH_LONG1;
              ev_fire         = 1'b1;
              ev_code         = EV_LONG1;
            end else if (phase == PH_LONG1 && held_inc == cfg.long2) begin
              prev_phase_next = phase;
              phase_next      = PH_LONG2;
              ev_fire         = 1'b1;
              ev_code         = EV_LONG2;
            end else if (phase == PH_LONG2 && held_inc == cfg.long3) begin
              prev_phase_next = phase;
              phase_next      = PH_LONG3;
              ev_fire         = 1'b1;
              ev_code         = EV_LONG3;
            end
          end else begin
            prev_phase_next = phase;
            phase_next      = PH_REL;
            gap_cnt_next    = '0;
          end
        end
        PH_LONG3: begin
          if (!down) begin
            prev_phase_next = phase;
            phase_next      = PH_REL;
            gap_cnt_next    = '0;
          end
        end
        PH_REL: begin
          if (!down) begin
            if (gap_inc >= cfg.rel_db) begin
              prev_phase_next = phase;
              phase_next      = PH_WAIT;
              gap_cnt_next    = '0;
            end else begin
              gap_cnt_next = gap_inc;
            end
          end else begin
            // release bounce clears the gap count
            phase_next   = prev_phase;
            gap_cnt_next = '0;
          end
        end
        PH_WAIT: begin
          if (down) begin
            prev_phase_next = phase;
            phase_next      = PH_PRE;
            gap_cnt_next    = '0;
          end else if (gap_cnt >= cfg.gap) begin
            // timeout compares the count before this tick's increment
            gap_cnt_next    = '0;
            held_cnt_next   = '0;
            tally_next      = '0;
            prev_phase_next = phase;
            phase_next      = PH_IDLE;
            ev_still        = 1'b0;
            if (tally == 2'd1) begin
              ev_fire = 1'b1;
              if (held_cnt < cfg.long1) begin
                ev_code = EV_SHORT;
              end else if (held_cnt < cfg.long2) begin
                ev_code = EV_LONG1;
              end else if (held_cnt < cfg.long3) begin
                ev_code = EV_LONG2;
              end else begin
                ev_code = EV_LONG3;
              end
            end else if (tally != 2'd0) begin
              ev_fire = 1'b1;
              ev_code = EV_DOUBLE;
            end
          end else begin
            gap_cnt_next = gap_inc;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        phase      <= PH_IDLE;
        prev_phase <= PH_IDLE;
        gap_cnt    <= '0;
        held_cnt   <= '0;
        tally      <= '0;
      end else if (accept) begin
        phase      <= phase_next;
        prev_phase <= prev_phase_next;
        gap_cnt    <= gap_cnt_next;
        held_cnt   <= held_cnt_next;
        tally      <= tally_next;
      end
    end
  end

  // ticks without any event never enter the queue
  assign push      = accept && (|ev_mask);
  assign push_data = {ev_mask, ev_kind, ev_held};

endmodule

### hdl/mkpc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpc_fifo
// Small queue of per-tick event records between the front and the back.
// ----------------------------------------------------------------------------
module mkpc_fifo #(
  parameter int WIDTH = 5 * mkpc_pkg::DEF_KEY_COUNT,
  parameter int DEPTH = mkpc_pkg::DEF_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import mkpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

### hdl/mkpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpc_back
// Takes one tick record at a time and emits its events lowest key first,
// one per cycle while not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module mkpc_back #(
  parameter int KEY_COUNT = mkpc_pkg::DEF_KEY_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [KEY_COUNT*5-1:0]         rd_data,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mkpc_pkg::KEY_IDX_W-1:0] key_index,
  output logic [mkpc_pkg::KIND_W-1:0]    event_kind,
  output logic                           still_held,
  output logic                           last_event
);
  import mkpc_pkg::*;

  logic                             cur_valid;
  logic [KEY_COUNT-1:0]             cur_mask;
  logic [KEY_COUNT-1:0][KIND_W-1:0] cur_kind;
  logic [KEY_COUNT-1:0]             cur_held;

  logic [KEY_COUNT-1:0] sel_onehot;
  logic [KEY_COUNT-1:0] rem_mask;
  logic [KEY_IDX_W-1:0] sel_idx;
  logic [KIND_W-1:0]    sel_kind;
  logic                 sel_held;
  logic                 found;
  logic                 advance;
  logic                 done;

  // lowest pending key
  always_comb begin
    found      = 1'b0;
    sel_onehot = '0;
    sel_idx    = '0;
    sel_kind   = '0;
    sel_held   = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (cur_mask[k] && !found) begin
        found         = 1'b1;
        sel_onehot[k] = 1'b1;
        sel_idx       = KEY_IDX_W'(k);
        sel_kind      = cur_kind[k];
        sel_held      = cur_held[k];
      end
    end
  end

  assign rem_mask = cur_mask & ~sel_onehot;
  assign advance  = cur_valid && (!out_valid || !out_stall);
  assign done     = advance && (rem_mask == '0);
  assign pop      = !empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mask <= rd_data[KEY_COUNT*5-1 -: KEY_COUNT];
      cur_kind <= rd_data[KEY_COUNT*4-1 : KEY_COUNT];
      cur_held <= rd_data[KEY_COUNT-1:0];
    end else if (advance) begin
      cur_mask <= rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_index  <= sel_idx;
      event_kind <= sel_kind;
      still_held <= sel_held;
      last_event <= (rem_mask == '0);
    end
  end

`ifndef SYNTHESIS
  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
      cur_valid |-> (cur_mask != '0))
    else $error("tick record held with no pending event");
  a_stall_holds_key: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> $stable(key_index))
    else $error("event changed under stall");
`endif

endmodule

### hdl/multi_key_press_classifier_core.sv
`timescale 1ns / 1ps
// Path: a tick's record is queued, loaded into the back end, then registered out.
// Throughput: one tick per cycle in unless in_stall, one event per cycle out unless
// out_stall; a tick raises up to 16 events, which leave one at a time.
// The event queue holds 4 ticks; the input stalls only when it is full or in reset.
// Reset: synchronous, active high; all keys go idle, registers take defaults.
// ----------------------------------------------------------------------------
// multi_key_press_classifier_core
// Debounce, long-press stages and double-click detection for up to 16 keys,
// with a decoupled classifier front end and an event serializer back end.
// ----------------------------------------------------------------------------
module multi_key_press_classifier_core #(
  parameter int KEY_COUNT  = mkpc_pkg::DEF_KEY_COUNT,
  parameter int FIFO_DEPTH = mkpc_pkg::DEF_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_write,
  input  logic [mkpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkpc_pkg::CNT_W-1:0]     cfg_data,
  // scan tick input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mkpc_pkg::TICK_W-1:0]    raw_pressed,
  // event output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mkpc_pkg::KEY_IDX_W-1:0] key_index,
  output logic [mkpc_pkg::KIND_W-1:0]    event_kind,
  output logic                           still_held,
  output logic                           last_event
);
  import mkpc_pkg::*;

  localparam int REC_W = KEY_COUNT * 5;

  cfg_t             cfg;
  logic             accept;
  logic             push;
  logic [REC_W-1:0] push_data;
  logic             pop;
  logic [REC_W-1:0] rd_data;
  logic             q_full;
  logic             q_empty;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_db <= RST_PRESS_DB;
      cfg.rel_db   <= RST_REL_DB;
      cfg.long1    <= RST_LONG1;
      cfg.long2    <= RST_LONG2;
      cfg.long3    <= RST_LONG3;
      cfg.gap      <= RST_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESS_DB: cfg.press_db <= cfg_data;
        REG_REL_DB:   cfg.rel_db   <= cfg_data;
        REG_LONG1:    cfg.long1    <= cfg_data;
        REG_LONG2:    cfg.long2    <= cfg_data;
        REG_LONG3:    cfg.long3    <= cfg_data;
        REG_GAP:      cfg.gap      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stall only on a full queue (or in reset), so the front keeps stepping
  // every tick while the back drains earlier events.
  assign in_stall = rst || q_full;
  assign accept   = in_valid && !in_stall;

  mkpc_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .raw_pressed (raw_pressed),
    .push        (push),
    .push_data   (push_data)
  );

  mkpc_fifo #(
    .WIDTH (REC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end walks each tick record lowest key first and flags the last.
  mkpc_back #(
    .KEY_COUNT (KEY_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_data    (rd_data),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_index  (key_index),
    .event_kind (event_kind),
    .still_held (still_held),
    .last_event (last_event)
  );

endmodule

### dv/multi_key_press_classifier_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_press_classifier_core_tb
// Self-checking bench for the 16-key press classifier. Scan ticks go in from
// a queue, and every accepted tick runs through a local per-key model that
// queues the events it should raise. Events coming out are checked in order,
// field by field. The run covers short directed sequences and randomized
// press/release scripts under several register settings and handshake
// idling mixes.
// ----------------------------------------------------------------------------
module multi_key_press_classifier_core_tb;
  import mkpc_pkg::*;

  localparam int NUM_KEYS       = DEF_KEY_COUNT;
  localparam int TICKS_PER_SET  = 21;     // random ticks per register setting
  localparam int RUN_CAP        = 40;     // longest scripted level run
  localparam int TAIL_CYCLES    = 80;     // idle wait after the last expected event
  localparam int DRAIN_LIMIT    = 20000;  // cycles to wait for missing events
  localparam int REPORT_LINES   = 40;

  // Indexes the block has no register for; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    KS_IDLE, KS_PRESS_DB, KS_HELD, KS_LONG1, KS_LONG2, KS_LONG3, KS_REL_DB, KS_WAIT
  } key_state_e;

  typedef enum logic [KIND_W-1:0] {
    EV_SHORT, EV_LONG1, EV_LONG2, EV_LONG3, EV_DOUBLE
  } event_kind_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key_index;
    logic [KIND_W-1:0]    event_kind;
    logic                 still_held;
    logic                 last_event;
  } exp_event_t;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CNT_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [TICK_W-1:0]    raw_pressed = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [KEY_IDX_W-1:0] key_index;
  logic [KIND_W-1:0]    event_kind;
  logic                 still_held;
  logic                 last_event;

  multi_key_press_classifier_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_pressed(raw_pressed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_index  (key_index),
    .event_kind (event_kind),
    .still_held (still_held),
    .last_event (last_event)
  );

  // Register shadow used by the key model
  logic [CNT_W-1:0] press_db, rel_db, long1_at, long2_at, long3_at, gap_limit;

  // Per-key model state
  key_state_e       key_phase  [NUM_KEYS];
  key_state_e       key_prev   [NUM_KEYS];
  logic [CNT_W-1:0] key_gap    [NUM_KEYS];
  logic [CNT_W-1:0] key_held   [NUM_KEYS];
  logic [1:0]       key_clicks [NUM_KEYS];

  // Scripted finger levels for the random part
  bit               finger_level [NUM_KEYS];
  int unsigned      finger_run   [NUM_KEYS];

  logic [TICK_W-1:0] pending_ticks[$];
  exp_event_t        expected_events[$];
  exp_event_t        head_event;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          tick_taken    = 1'b0;
  int unsigned err_count     = 0;
  int unsigned ticks_sent    = 0;
  int unsigned events_seen   = 0;
  int unsigned settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("Timed out waiting on the block");
    $display("Regression FAIL");
    $finish;
  end

  task automatic report(input string msg);
    err_count++;
    if (err_count <= REPORT_LINES) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void move_to(input int k, input key_state_e nxt);
    key_prev[k]  = key_phase[k];
    key_phase[k] = nxt;
  endfunction

  function automatic void reset_model();
    press_db  = RST_PRESS_DB;
    rel_db    = RST_REL_DB;
    long1_at  = RST_LONG1;
    long2_at  = RST_LONG2;
    long3_at  = RST_LONG3;
    gap_limit = RST_GAP;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_phase[k]    = KS_IDLE;
      key_prev[k]     = KS_IDLE;
      key_gap[k]      = '0;
      key_held[k]     = '0;
      key_clicks[k]   = '0;
      finger_level[k] = 1'b0;
      finger_run[k]   = $urandom_range(4, 1);
    end
  endfunction

  // Advance every key by one scan tick and queue the events it raises,
  // lowest key first, with the last one of the tick marked.
  function automatic void predict_tick(input logic [TICK_W-1:0] scan);
    exp_event_t  tick_events[$];
    exp_event_t  ev;
    bit          down;
    bit          fire;
    bit          timed_out;
    logic        still_down;
    event_kind_e kind;
    for (int k = 0; k < NUM_KEYS; k++) begin
      down       = scan[k];
      fire       = 1'b0;
      still_down = 1'b1;
      kind       = EV_SHORT;
      case (key_phase[k])
        KS_IDLE: begin
          if (down) begin
            move_to(k, KS_PRESS_DB);
            key_gap[k] = '0;
          end
        end
        KS_PRESS_DB: begin
          if (down) begin
            key_gap[k] = sat_bump(key_gap[k]);
            if (key_gap[k] >= press_db) begin
              key_gap[k]  = '0;
              key_held[k] = '0;
              if (key_clicks[k] != 2'd3) key_clicks[k] = key_clicks[k] + 1'b1;
              move_to(k, KS_HELD);
              fire = 1'b1;
              kind = EV_SHORT;
            end
          end else begin
            // press bounce: back where we came from, gap count kept
            key_phase[k] = key_prev[k];
          end
        end
        KS_HELD, KS_LONG1, KS_LONG2: begin
          if (down) begin
            key_held[k] = sat_bump(key_held[k]);
            // only a first click may climb the long stages
            if (key_phase[k] == KS_HELD && key_clicks[k] == 2'd1 &&
                key_held[k] == long1_at) begin
              move_to(k, KS_LONG1);
              fire = 1'b1;
              kind = EV_LONG1;
            end else if (key_phase[k] == KS_LONG1 && key_held[k] == long2_at) begin
              move_to(k, KS_LONG2);
              fire = 1'b1;
              kind = EV_LONG2;
            end else if (key_phase[k] == KS_LONG2 && key_held[k] == long3_at) begin
              move_to(k, KS_LONG3);
              fire = 1'b1;
              kind = EV_LONG3;
            end
          end else begin
            move_to(k, KS_REL_DB);
            key_gap[k] = '0;
          end
        end
        KS_LONG3: begin
          if (!down) begin
            move_to(k, KS_REL_DB);
            key_gap[k] = '0;
          end
        end
        KS_REL_DB: begin
          if (!down) begin
            key_gap[k] = sat_bump(key_gap[k]);
            if (key_gap[k] >= rel_db) begin
              move_to(k, KS_WAIT);
              key_gap[k] = '0;
            end
          end else begin
            // release bounce: resume the held stage, gap count cleared
            key_phase[k] = key_prev[k];
            key_gap[k]   = '0;
          end
        end
        default: begin
          if (down) begin
            move_to(k, KS_PRESS_DB);
            key_gap[k] = '0;
          end else begin
            // timeout is judged on the count before this tick's increment
            timed_out  = (key_gap[k] >= gap_limit);
            key_gap[k] = sat_bump(key_gap[k]);
            if (timed_out) begin
              if (key_clicks[k] == 2'd1) begin
                fire = 1'b1;
                if (key_held[k] < long1_at)      kind = EV_SHORT;
                else if (key_held[k] < long2_at) kind = EV_LONG1;
                else if (key_held[k] < long3_at) kind = EV_LONG2;
                else                             kind = EV_LONG3;
              end else if (key_clicks[k] != 2'd0) begin
                fire = 1'b1;
                kind = EV_DOUBLE;
              end
              key_gap[k]    = '0;
              key_held[k]   = '0;
              key_clicks[k] = '0;
              move_to(k, KS_IDLE);
              still_down = 1'b0;
            end
          end
        end
      endcase
      if (fire) begin
        ev.key_index  = KEY_IDX_W'(k);
        ev.event_kind = kind;
        ev.still_held = still_down;
        ev.last_event = 1'b0;
        tick_events.push_back(ev);
      end
    end
    if (tick_events.size() > 0) tick_events[tick_events.size() - 1].last_event = 1'b1;
    foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
  endfunction

  // Length of the next level run for one finger: mostly clean presses and
  // releases sized around the current thresholds, some bounces.
  function automatic int unsigned pick_run(input bit down);
    int unsigned pick, pdb, rdb, run;
    pick = $urandom_range(9);
    pdb  = (press_db == 0) ? 1 : press_db;
    rdb  = (rel_db == 0) ? 1 : rel_db;
    if (down) begin
      if (pick < 2)      run = (pdb > 1) ? $urandom_range(pdb - 1, 1) : 1;
      else if (pick < 6) run = pdb + $urandom_range(long1_at);
      else               run = pdb + $urandom_range(long3_at + 3, long1_at);
    end else begin
      if (pick < 2)      run = (rdb > 1) ? $urandom_range(rdb - 1, 1) : 1;
      else if (pick < 6) run = rdb + $urandom_range(gap_limit);  // second click
      else               run = rdb + gap_limit + 1 + $urandom_range(3);
    end
    return (run > RUN_CAP) ? RUN_CAP : run;
  endfunction

  function automatic logic [TICK_W-1:0] next_scan(input logic [TICK_W-1:0] active);
    logic [TICK_W-1:0] scan;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (finger_run[k] == 0) begin
        finger_level[k] = !finger_level[k];
        finger_run[k]   = pick_run(finger_level[k]);
      end
      finger_run[k]--;
      scan[k] = finger_level[k] & active[k];
    end
    // occasional glitch on a random line
    if ($urandom_range(19) == 0) scan[$urandom_range(NUM_KEYS - 1)] ^= 1'b1;
    return scan;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PRESS_DB: press_db  = val;
      REG_REL_DB:   rel_db    = val;
      REG_LONG1:    long1_at  = val;
      REG_LONG2:    long2_at  = val;
      REG_LONG3:    long3_at  = val;
      REG_GAP:      gap_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CNT_W-1:0] pdb, input logic [CNT_W-1:0] rdb,
                            input logic [CNT_W-1:0] l1, input logic [CNT_W-1:0] l2,
                            input logic [CNT_W-1:0] l3, input logic [CNT_W-1:0] gap);
    write_reg(REG_PRESS_DB, pdb);
    write_reg(REG_REL_DB, rdb);
    write_reg(REG_LONG1, l1);
    write_reg(REG_LONG2, l2);
    write_reg(REG_LONG3, l3);
    write_reg(REG_GAP, gap);
    settings_used++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 75; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 75; end
      IDLE_BOTH:     begin send_idle_pct = 32; stall_pct = 32; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic queue_ticks(input logic [TICK_W-1:0] scan, input int unsigned count);
    repeat (count) pending_ticks.push_back(scan);
  endtask

  // Wait until every tick is in and every expected event is out, then
  // wait out TAIL_CYCLES before the next register write.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (pending_ticks.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_events.size() != 0) begin
      report($sformatf("%0d expected events never arrived", expected_events.size()));
      expected_events.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Driver: presents the next tick on the falling edge; a tick stays put
  // until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        raw_pressed <= pending_ticks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Monitor: checks events leaving the block, then feeds any tick taken on
  // this edge to the key model.
  always @(posedge clk) begin
    if (rst) begin
      tick_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected event: key %0d kind %0d held %0d last %0d",
                           key_index, event_kind, still_held, last_event));
        end else begin
          head_event = expected_events.pop_front();
          if (key_index !== head_event.key_index)
            report($sformatf("key_index got %0d want %0d", key_index,
                             head_event.key_index));
          if (event_kind !== head_event.event_kind)
            report($sformatf("key %0d event_kind got %0d want %0d", head_event.key_index,
                             event_kind, head_event.event_kind));
          if (still_held !== head_event.still_held)
            report($sformatf("key %0d still_held got %0d want %0d", head_event.key_index,
                             still_held, head_event.still_held));
          if (last_event !== head_event.last_event)
            report($sformatf("key %0d last_event got %0d want %0d", head_event.key_index,
                             last_event, head_event.last_event));
        end
      end
      tick_taken = in_valid && !in_stall;
      if (tick_taken) begin
        predict_tick(raw_pressed);
        ticks_sent++;
      end
    end
  end

  initial begin : stimulus
    int unsigned       l1, l2, l3;
    logic [TICK_W-1:0] active;
    reset_model();
    wait (!rst);
    @(posedge clk);
    set_idling(IDLE_NONE);

    // Reset values: every key confirms its press on the same tick
    queue_ticks(16'hFFFF, 3);
    settle();

    // Tight thresholds; spare indexes must not disturb anything
    set_config(16'd1, 16'd1, 16'd2, 16'd3, 16'd4, 16'd1);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    @(posedge clk);
    // climb the first two long stages, then release into a final long verdict
    queue_ticks(16'hFFFF, 5);
    queue_ticks(16'h0000, 4);
    // odd keys: press, release bounce, second click held past stage one
    // (no long event on a later click), ending in a double click;
    // even keys: a press bounce from idle
    queue_ticks(16'hAAAA, 2);
    queue_ticks(16'h5555, 1);
    queue_ticks(16'hAAAA, 1);
    queue_ticks(16'h0000, 2);
    queue_ticks(16'hAAAA, 4);
    queue_ticks(16'h0000, 4);
    settle();

    // Random finger scripts under a handful of settings
    for (int p = 0; p < 5; p++) begin
      if (p < 4) begin
        l1 = $urandom_range(5, 2);
        l2 = l1 + $urandom_range(4, 1);
        l3 = l2 + $urandom_range(4, 1);
        set_config(CNT_W'($urandom_range(3, 1)), CNT_W'($urandom_range(3, 1)),
                   CNT_W'(l1), CNT_W'(l2), CNT_W'(l3),
                   CNT_W'($urandom_range(5, 1)));
        set_idling(idle_mode_e'(p));
      end else begin
        // zero debounce and gap, a third stage that is never reached
        set_config(16'd0, 16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd0);
        set_idling(IDLE_BOTH);
      end
      active = (p == 0 || p == 3) ? 16'hFFFF : TICK_W'($urandom_range(16'hFFFF, 1));
      @(posedge clk);
      repeat (TICKS_PER_SET) pending_ticks.push_back(next_scan(active));
      settle();
    end

    $display("Checked %0d events from %0d scan ticks over %0d register settings",
             events_seen, ticks_sent, settings_used);
    $display("Covered bounces, long stages, multi-clicks and handshake idling mixes");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/mkpc_pkg.sv
hdl/mkpc_front.sv
hdl/mkpc_fifo.sv
hdl/mkpc_back.sv
hdl/multi_key_press_classifier_core.sv
dv/multi_key_press_classifier_core_tb.sv
